// ----- sv/sacp_pkg.sv -----
// Package: geometry constants, row type and sequencer states for the prefetching cache.
`timescale 1ns / 1ps
`default_nettype none
package sacp_pkg;

    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 16;
    localparam int ADDR_W   = 48;
    localparam int CNT_W    = 32;

    localparam int SET_AW   = $clog2(MAX_SETS);
    localparam int WAY_CW   = $clog2(MAX_WAYS + 1);
    localparam int SB_W     = 4;
    localparam int BB_W     = 4;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 5;

    localparam logic [CFG_IW-1:0] CFG_BLOCK_BITS = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SET_BITS   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WAYS_USED  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_PREFETCH   = 2'd3;

    localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 4'd6;
    localparam logic [SB_W-1:0]   SET_BITS_RST   = 4'd0;
    localparam logic [WAY_CW-1:0] WAYS_RST       = WAY_CW'(1);

    typedef struct packed {
        logic [MAX_WAYS-1:0]             vld;
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
    } t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPLIT,
        S_READ,
        S_CMP
    } t_state;

endpackage
`default_nettype wire

// ----- sv/set_assoc_fifo_cache_prefetch.sv -----
// Top level: tag-only set-associative cache with FIFO fill and next-line prefetch.
`timescale 1ns / 1ps
`default_nettype none
// An access is taken when start is high and busy is low. One lookup unit (address split,
// row read from the single-port tag memory, parallel way compare) serves the demand lookup
// and then, after a demand miss with prefetch enabled, the next-block lookup. Each lookup
// reads one set row and, on a miss, writes it back with the new tag in way 0. It passes
// through the split, read and compare states, and o_valid is registered from the last
// compare; busy falls in the strobe cycle, so a new access can be taken then. The result is shown for
// exactly one cycle and the receiver cannot stall it. Rows carry a written-since-reset
// flag in flip-flops, so no clearing pass follows reset. Configuration words are taken
// at any time but must only be written while the block is idle.
module set_assoc_fifo_cache_prefetch
    import sacp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_kind,
    input  wire  [ADDR_W-1:0]    i_address,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IW-1:0]    i_cfg_index,
    input  wire  [CFG_DW-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [1:0]           o_reads_added,
    output logic                 o_write_added,
    output logic [CNT_W-1:0]     o_total_hits,
    output logic [CNT_W-1:0]     o_total_misses,
    output logic [CNT_W-1:0]     o_total_reads,
    output logic [CNT_W-1:0]     o_total_writes
);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [BB_W-1:0]     r_block_bits;
    logic [SB_W-1:0]     r_set_bits;
    logic [WAY_CW-1:0]   r_ways_used;
    logic                r_pf_en;

    logic                r_kind, n_kind;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [SET_AW-1:0]   r_set, n_set;
    logic [ADDR_W-1:0]   r_tag, n_tag;
    logic                r_pf, n_pf;
    logic                r_hit, n_hit;
    logic [1:0]          r_reads, n_reads;
    logic [MAX_SETS-1:0] r_row_vld, n_row_vld;
    logic                r_row_ok;
    t_row                r_row_q;
    t_row                r_mem [MAX_SETS];

    logic                r_valid, n_valid;
    logic                r_o_hit, n_o_hit;
    logic [1:0]          r_o_reads, n_o_reads;
    logic                r_o_write, n_o_write;
    logic [CNT_W-1:0]    r_hits, n_hits;
    logic [CNT_W-1:0]    r_misses, n_misses;
    logic [CNT_W-1:0]    r_rd_cnt, n_rd_cnt;
    logic [CNT_W-1:0]    r_wr_cnt, n_wr_cnt;

    logic                mem_we;
    t_row                fill_row;
    logic [SB_W-1:0]     eff_sb;
    logic [WAY_CW-1:0]   eff_ways;
    logic [ADDR_W-1:0]   blk;
    logic                lookup_hit;

    always_comb begin
        logic [MAX_WAYS-1:0] v_eff;
        logic [1:0]          reads_fin;
        logic                last;

        eff_sb   = (r_set_bits > SB_W'(SET_AW)) ? SB_W'(SET_AW) : r_set_bits;
        eff_ways = (r_ways_used == '0) ? WAY_CW'(1) :
                   (r_ways_used > WAY_CW'(MAX_WAYS)) ? WAY_CW'(MAX_WAYS) : r_ways_used;
        blk      = r_addr >> r_block_bits;

        lookup_hit = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            v_eff[i] = r_row_ok & r_row_q.vld[i];
            if (v_eff[i] && (r_row_q.tag[i] == r_tag) && (WAY_CW'(i) < eff_ways)) begin
                lookup_hit = 1'b1;
            end
        end

        fill_row.tag[0] = r_tag;
        fill_row.vld[0] = 1'b1;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (WAY_CW'(i) < eff_ways) begin
                fill_row.tag[i] = r_row_q.tag[i-1];
                fill_row.vld[i] = v_eff[i-1];
            end else begin
                fill_row.tag[i] = r_row_q.tag[i];
                fill_row.vld[i] = v_eff[i];
            end
        end

        n_state   = r_state;
        n_kind    = r_kind;
        n_addr    = r_addr;
        n_set     = r_set;
        n_tag     = r_tag;
        n_pf      = r_pf;
        n_hit     = r_hit;
        n_reads   = r_reads;
        n_row_vld = r_row_vld;
        n_valid   = 1'b0;
        n_o_hit   = r_o_hit;
        n_o_reads = r_o_reads;
        n_o_write = r_o_write;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_rd_cnt  = r_rd_cnt;
        n_wr_cnt  = r_wr_cnt;
        mem_we    = 1'b0;
        reads_fin = r_reads;
        last      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_addr  = i_address;
                    n_pf    = 1'b0;
                    n_hit   = 1'b0;
                    n_reads = 2'd0;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                n_set   = blk[SET_AW-1:0] & ~({SET_AW{1'b1}} << eff_sb);
                n_tag   = blk >> eff_sb;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!lookup_hit) begin
                    mem_we           = 1'b1;
                    n_row_vld[r_set] = 1'b1;
                    reads_fin        = r_reads + 2'd1;
                end
                if (r_pf) begin
                    last = 1'b1;
                end else if (lookup_hit) begin
                    n_hit = 1'b1;
                    last  = 1'b1;
                end else if (!r_pf_en) begin
                    last = 1'b1;
                end else begin
                    n_reads = reads_fin;
                    n_pf    = 1'b1;
                    n_addr  = r_addr + (ADDR_W'(1) << r_block_bits);
                    n_state = S_SPLIT;
                end
                if (last) begin
                    n_valid   = 1'b1;
                    n_o_hit   = n_hit;
                    n_o_reads = reads_fin;
                    n_o_write = r_kind;
                    n_hits    = sat_add(r_hits, {1'b0, n_hit});
                    n_misses  = sat_add(r_misses, {1'b0, ~n_hit});
                    n_rd_cnt  = sat_add(r_rd_cnt, reads_fin);
                    n_wr_cnt  = sat_add(r_wr_cnt, {1'b0, r_kind});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row_vld    <= '0;
            r_valid      <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_rd_cnt     <= '0;
            r_wr_cnt     <= '0;
            r_block_bits <= BLOCK_BITS_RST;
            r_set_bits   <= SET_BITS_RST;
            r_ways_used  <= WAYS_RST;
            r_pf_en      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_vld <= n_row_vld;
            r_valid   <= n_valid;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_rd_cnt  <= n_rd_cnt;
            r_wr_cnt  <= n_wr_cnt;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SB_W-1:0];
                    CFG_WAYS_USED:  r_ways_used  <= i_cfg_data[WAY_CW-1:0];
                    CFG_PREFETCH:   r_pf_en      <= i_cfg_data[0];
                    default:        r_pf_en      <= r_pf_en;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_addr    <= n_addr;
        r_set     <= n_set;
        r_tag     <= n_tag;
        r_pf      <= n_pf;
        r_hit     <= n_hit;
        r_reads   <= n_reads;
        r_o_hit   <= n_o_hit;
        r_o_reads <= n_o_reads;
        r_o_write <= n_o_write;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_set] <= fill_row;
        end
        if (r_state == S_READ) begin
            r_row_q  <= r_mem[r_set];
            r_row_ok <= r_row_vld[r_set];
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_hit          = r_o_hit;
    assign o_reads_added  = r_o_reads;
    assign o_write_added  = r_o_write;
    assign o_total_hits   = r_hits;
    assign o_total_misses = r_misses;
    assign o_total_reads  = r_rd_cnt;
    assign o_total_writes = r_wr_cnt;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_hit_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_reads_added == 2'd0))
        else $error("hit reported memory reads");

    a_miss_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_reads_added == 2'd1 || o_reads_added == 2'd2))
        else $error("miss reported no memory read");

endmodule
`default_nettype wire
